// ----- design/bpt_pkg.sv -----
package bpt_pkg;

   localparam int MaxCodeBits = 16;
   localparam int ChunkLen    = 64;
   localparam int GroupChunks = 8;
   localparam int GroupShift  = $clog2(GroupChunks);
   localparam int Layout1Bits = 8;

   localparam int CodeW    = 16;
   localparam int PlaneW   = ChunkLen;
   localparam int ElemW    = $clog2(ChunkLen);
   localparam int ChunkW   = 16;
   localparam int VecW     = 17;
   localparam int BitsW    = 5;
   localparam int IdxW     = 20;
   localparam int StepW    = $clog2(GroupChunks) + 1;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 17;

   localparam logic [ElemW-1:0] LastElem  = ElemW'(ChunkLen - 1);
   localparam logic [BitsW-1:0] BitsReset = BitsW'(4);
   localparam logic [VecW-1:0]  VecReset  = VecW'(1);
   localparam logic [VecW-1:0]  VecMax    = VecW'(65536);

   localparam logic [CsrIdxW-1:0] CsrBitsPerCode     = CsrIdxW'(0);
   localparam logic [CsrIdxW-1:0] CsrLayoutMode      = CsrIdxW'(1);
   localparam logic [CsrIdxW-1:0] CsrChunksPerVector = CsrIdxW'(2);

   // Control that every cell of the chain sees.
   typedef struct packed {
      logic shift;    // a code beat was accepted
      logic load;     // chunk complete: capture planes
      logic advance;  // output beat taken: move planes toward cell 0
   } chain_ctrl_type;

   // Configuration in force, already saturated.
   typedef struct packed {
      logic [BitsW-1:0] nbits;
      logic             layout1;
      logic [VecW-1:0]  nchunks;
   } bpt_cfg_type;

endpackage

// ----- design/bpt_cell.sv -----
module bpt_cell
   import bpt_pkg::*;
(
   input  logic                clock,
   input  logic                code_bit,
   input  logic                zero_plane,
   input  chain_ctrl_type      ctrl,
   input  logic [PlaneW-1:0]   neighbor_in,
   output logic [PlaneW-1:0]   hold_out
);

   logic [PlaneW-1:0] acc_ff, acc_in;
   logic [PlaneW-1:0] hold_ff, hold_in;

   // Newest element enters at bit 0, so element i ends up at bit 63-i.
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.shift) begin
         acc_in = {acc_ff[PlaneW-2:0], code_bit};
      end
   end

   // Load the finished plane (zeroed if zero_plane), else take the neighbor's plane on each beat.
   always_comb begin
      hold_in = hold_ff;
      if (ctrl.load) begin
         hold_in = zero_plane ? '0 : {acc_ff[PlaneW-2:0], code_bit};
      end else if (ctrl.advance) begin
         hold_in = neighbor_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      hold_ff <= hold_in;
   end

   assign hold_out = hold_ff;

endmodule

// ----- design/bpt_emit.sv -----
module bpt_emit
   import bpt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  bpt_cfg_type        cfg,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [IdxW-1:0]    word_index,
   output logic               last_plane,
   output logic               advance,
   output logic               bank_free
);

   logic [BitsW-1:0]  remain_ff, remain_in;
   logic [IdxW-1:0]   idx_ff, idx_in;
   logic [StepW-1:0]  step_ff, step_in;
   logic [ChunkW-1:0] chunk_ff, chunk_in;

   logic [ChunkW-1:0]     gstart;
   logic [GroupShift-1:0] in_group;
   logic [VecW-1:0]       diff;
   logic [StepW-1:0]      members;
   logic [ChunkW-1:0]     mul_a;
   logic [ChunkW+BitsW-1:0] product;
   logic [IdxW-1:0]       base;
   logic [VecW-1:0]       chunk_inc;

   always_comb begin
      gstart   = {chunk_ff[ChunkW-1:GroupShift], {GroupShift{1'b0}}};
      in_group = chunk_ff[GroupShift-1:0];
      diff     = cfg.nchunks - {1'b0, gstart};
      // Short last group of a vector; full group otherwise.
      if ((cfg.nchunks > {1'b0, gstart}) && (diff < VecW'(GroupChunks))) begin
         members = diff[StepW-1:0];
      end else begin
         members = StepW'(GroupChunks);
      end
      mul_a   = cfg.layout1 ? gstart : chunk_ff;
      product = (ChunkW+BitsW)'(mul_a) * (ChunkW+BitsW)'(cfg.nbits);
      base    = product[IdxW-1:0] + (cfg.layout1 ? IdxW'(in_group) : '0);
      chunk_inc = {1'b0, chunk_ff} + VecW'(1);
   end

   assign rsp_valid  = (remain_ff != '0);
   assign advance    = rsp_valid && rsp_ready;
   assign last_plane = (remain_ff == BitsW'(1));
   assign word_index = idx_ff;
   assign bank_free  = (remain_ff == '0) || (last_plane && rsp_ready);

   always_comb begin
      remain_in = remain_ff;
      idx_in    = idx_ff;
      step_in   = step_ff;
      chunk_in  = chunk_ff;
      if (load) begin
         remain_in = cfg.nbits;
         idx_in    = base;
         step_in   = cfg.layout1 ? members : StepW'(1);
         chunk_in  = (chunk_inc >= cfg.nchunks) ? '0 : chunk_inc[ChunkW-1:0];
      end else if (advance) begin
         remain_in = remain_ff - BitsW'(1);
         idx_in    = idx_ff + IdxW'(step_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
         chunk_ff  <= '0;
      end else begin
         remain_ff <= remain_in;
         chunk_ff  <= chunk_in;
      end
      idx_ff  <= idx_in;
      step_ff <= step_in;
   end

`ifndef SYNTHESIS
   a_remain_bound: assert property (@(posedge clock) disable iff (reset)
      remain_ff <= BitsW'(MaxCodeBits))
      else $error("plane count exceeds code bits");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (advance && !load && (remain_ff > BitsW'(1)))
      |=> (idx_ff == $past(idx_ff + IdxW'(step_ff))))
      else $error("word index did not advance by the step");

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      load |=> (remain_ff == $past(cfg.nbits)))
      else $error("plane count not loaded from configuration");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> bank_free)
      else $error("chunk captured over undelivered planes");
`endif

endmodule

// ----- design/bit_plane_transposer.sv -----
// Bit-plane transposer.
// req_ channel: one 16-bit code per beat. Every 64 codes form a chunk; code i
//   of a chunk lands at bit 63-i of each plane.
// rsp_ channel: after the 64th code of a chunk, one beat per code bit, low bit
//   first: the 64-bit plane, its destination word index and a last flag on the
//   final plane of the chunk. bits_per_code of 0 gives no beats.
// csr_ channel: index 0 bits_per_code, 1 layout_mode, 2 chunks_per_vector;
//   always ready, write only while the block is idle.
// Output pacing: the first plane is valid the cycle after the 64th code is taken;
//   the rest follow one per cycle while rsp_ready is high.
// Throughput: one code per cycle sustained. The drain of a chunk overlaps the
//   next fill, set by one plane hold register per cell. The 64th code of a
//   chunk waits only if the previous chunk's planes are still undelivered.
// Reset: element and chunk counters clear, no planes pending, registers take
//   4 bits, layout 0, one chunk per vector.
// Receiver stall: planes hold in the cell chain; codes keep flowing until the
//   next chunk completes.
module bit_plane_transposer
   import bpt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CodeW-1:0]    req_code_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [PlaneW-1:0]   rsp_plane_word,
   output logic [IdxW-1:0]     rsp_word_index,
   output logic                rsp_last_plane,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   logic [BitsW-1:0] bits_ff, bits_in;
   logic             layout_ff, layout_in;
   logic [VecW-1:0]  chunks_ff, chunks_in;
   logic [ElemW-1:0] elem_ff, elem_in;

   bpt_cfg_type    cfg;
   chain_ctrl_type ctrl;
   logic           req_accept;
   logic           load;
   logic           advance;
   logic           bank_free;
   logic [PlaneW-1:0] hold_bus [MaxCodeBits];

   // Configuration writes; codes beyond the register list are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      bits_in   = bits_ff;
      layout_in = layout_ff;
      chunks_in = chunks_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrBitsPerCode:     bits_in   = csr_wdata[BitsW-1:0];
            CsrLayoutMode:      layout_in = csr_wdata[0];
            CsrChunksPerVector: chunks_in = csr_wdata[VecW-1:0];
            default: ;
         endcase
      end
   end

   // Saturate the raw register values.
   always_comb begin
      cfg.nbits   = (bits_ff > BitsW'(MaxCodeBits)) ? BitsW'(MaxCodeBits) : bits_ff;
      cfg.layout1 = layout_ff;
      if (chunks_ff == '0) begin
         cfg.nchunks = VecW'(1);
      end else if (chunks_ff > VecMax) begin
         cfg.nchunks = VecMax;
      end else begin
         cfg.nchunks = chunks_ff;
      end
   end

   // Stall only the chunk-closing beat, and only while planes are pending.
   assign req_ready  = (elem_ff != LastElem) || bank_free;
   assign req_accept = req_valid && req_ready;
   assign load       = req_accept && (elem_ff == LastElem);
   assign elem_in    = req_accept ? elem_ff + ElemW'(1) : elem_ff;

   always_comb begin
      ctrl.shift   = req_accept;
      ctrl.load    = load;
      ctrl.advance = advance;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff   <= BitsReset;
         layout_ff <= 1'b0;
         chunks_ff <= VecReset;
         elem_ff   <= '0;
      end else begin
         bits_ff   <= bits_in;
         layout_ff <= layout_in;
         chunks_ff <= chunks_in;
         elem_ff   <= elem_in;
      end
   end

   // One cell per code bit; planes move toward cell 0, which drives the output.
   for (genvar b = 0; b < MaxCodeBits; b++) begin : g_cell
      logic [PlaneW-1:0] neighbor;
      if (b == MaxCodeBits - 1) begin : g_end
         assign neighbor = '0;
      end else begin : g_mid
         assign neighbor = hold_bus[b+1];
      end
      bpt_cell u_cell (
         .clock       (clock),
         .code_bit    (req_code_value[b]),
         .zero_plane  (layout_ff && (b >= Layout1Bits)),
         .ctrl        (ctrl),
         .neighbor_in (neighbor),
         .hold_out    (hold_bus[b])
      );
   end

   bpt_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .cfg        (cfg),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .word_index (rsp_word_index),
      .last_plane (rsp_last_plane),
      .advance    (advance),
      .bank_free  (bank_free)
   );

   assign rsp_plane_word = hold_bus[0];

endmodule
